// ===== rtl/core/cbes_pkg.sv =====
// Shared types, codes and constants of the conveyor blind ejector scheduler.
`timescale 1ns / 1ps
package cbes_pkg;

  localparam int SLOTS_DEF   = 8;
  localparam int CD_PER_SLOT = 5;
  localparam int MAX_RES     = 32;
  localparam int CNT_W       = 6;
  localparam int NUM_W       = 45;
  localparam int DEN_W       = 22;

  localparam logic [31:0] NO_KICK      = 32'd9999999;
  localparam logic [15:0] KICK_MS      = 16'd400;
  localparam logic [15:0] RETRACT_MS   = 16'd200;
  localparam logic [6:0]  REST_ANGLE   = 7'd90;
  localparam logic [6:0]  STRIKE_ANGLE = 7'd0;
  localparam int          END_EXTRA_MS = 1000;
  localparam logic [9:0]  MS_PER_S_DIV = 10'd1000;

  localparam logic [2:0] REG_BOX_LEN  = 3'd0;
  localparam logic [2:0] REG_ZONE1    = 3'd1;
  localparam logic [2:0] REG_ZONE2    = 3'd2;
  localparam logic [2:0] REG_ZONE3    = 3'd3;
  localparam logic [2:0] REG_KICK_OFS = 3'd4;
  localparam logic [2:0] REG_TYPES    = 3'd5;

  localparam logic [2:0] CD_S1   = 3'd0;
  localparam logic [2:0] CD_S3   = 3'd2;
  localparam logic [2:0] CD_KICK = 3'd3;
  localparam logic [2:0] CD_END  = 3'd4;

  localparam logic [1:0] PH_TRAVEL  = 2'd0;
  localparam logic [1:0] PH_KICK    = 2'd1;
  localparam logic [1:0] PH_RETRACT = 2'd2;

  localparam logic [1:0] NO_EJECTOR   = 2'd3;
  localparam logic [2:0] TYPE_NONE    = 3'd0;
  localparam logic [2:0] TYPE_UNKNOWN = 3'd1;

  typedef enum logic [1:0] {
    CMD_TICK, CMD_EDGE, CMD_SET_TYPE, CMD_ENABLE
  } cmd_t;

  typedef enum logic [2:0] {
    EV_NONE, EV_NEW_BOX, EV_SENSOR, EV_SERVO, EV_EJECT
  } event_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDI, S_RDC, S_CALC, S_SERVO, S_FMUL, S_FDIV, S_FWR, S_FNK, S_FEND,
    S_FINFO, S_PUSH, S_FIN
  } fsm_t;

  typedef struct packed {
    logic [2:0]  btype;
    logic [1:0]  ej;
    logic [2:0]  flags;
    logic [1:0]  phase;
    logic [15:0] sw;
  } slot_info_t;

  typedef struct packed {
    event_t     res;
    logic [2:0] btype;
    logic [1:0] sensor;
    logic [1:0] ejector;
    logic [6:0] angle;
  } ev_t;

endpackage

// ===== rtl/core/conveyor_blind_ejector_scheduler.sv =====
// Top level of the conveyor blind ejector scheduler: slot walk, edge math, event output.
//
//  channel | ports               | payload
//  --------+---------------------+------------------------------------------------
//  in      | in_tvalid/tready    | tuser cmd; tdata tick_ms, object_present, time_us,
//          |                     | box_type, enable
//  out     | out_tvalid/tready   | tuser event_res; tdata type, sensor, ejector,
//          |                     | angle; tlast last
//  cfg     | cfg_we/index/wdata  | six registers, index 0..5
//
// A tick walks the slots in turn: an active slot gets a slot read, 5 countdown read-modify-writes
// in the countdown RAM and one servo step, an idle slot is skipped, and each event is pushed.
// A falling edge that creates a box runs the bit-serial divider once for each of up to
// four distance countdowns.
// Reset is synchronous and clears all control state.
// A stalled output holds the block in place; the next item is taken once the final
// result of the current one sits in the output register.
`timescale 1ns / 1ps
module conveyor_blind_ejector_scheduler #(
  parameter int SLOTS = cbes_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [47:0] in_tdata,   // tick_ms, object_present, time_us, box_type, enable
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // event_res
  output logic [15:0] out_tdata,  // event_box_type, sensor_index, ejector_index, servo_angle
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);
  import cbes_pkg::*;

  localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW       = $clog2(SLOTS + 1);
  localparam int CD_DEPTH = SLOTS * CD_PER_SLOT;
  localparam int CAW      = $clog2(CD_DEPTH);
  localparam int IW       = $bits(slot_info_t);

  logic [11:0] len_r, zone1_r, zone2_r, zone3_r, kofs_r;
  logic [8:0]  types_r;

  fsm_t             state_r, state_nxt, ret_r, ret_nxt;
  logic             enabled_r, enabled_nxt, rise_v_r, rise_v_nxt;
  logic [2:0]       mtype_r, mtype_nxt;
  logic [31:0]      rise_r, rise_nxt, d_r, d_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [2:0]       j_r, j_nxt;
  logic [7:0]       tick_r, tick_nxt;
  logic [4:0]       le_r, le_nxt;
  slot_info_t       info_r, info_nxt;
  ev_t              evn_r, evn_nxt, pend_r, pend_nxt, out_r, out_nxt;
  logic             pend_v_r, pend_v_nxt, out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       ej_r, ej_nxt, m_r, m_nxt;
  logic             neg_r, neg_nxt;
  logic [DEN_W-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [NUM_W-1:0] num_r, num_nxt, q_r, q_nxt;
  logic [5:0]       bit_r, bit_nxt;
  logic [31:0]      s3_r, s3_nxt;

  cmd_t        cmd;
  logic [7:0]  f_tick;
  logic        f_present, f_enable;
  logic [31:0] f_time, f_d;
  logic [2:0]  f_type;
  logic        out_free, push_go;
  logic [SW-1:0] free_idx, kidx;
  logic        free_any;
  logic [1:0]  ej_match;
  logic [12:0] span, mag;
  logic signed [13:0] diff;
  logic [DEN_W:0] shifted;
  logic [31:0] qsat, cd_nv, end_v;
  logic signed [32:0] cd_diff, end_sum;
  logic [16:0] sw_sum;
  logic [15:0] sw_sat;
  logic [CAW-1:0] cd_base;

  logic           cd_we, cd_re, inf_we, inf_re;
  logic [CAW-1:0] cd_waddr, cd_raddr;
  logic [31:0]    cd_wdata, cd_rdata;
  slot_info_t     inf_wdata, inf_rdata;

  assign cmd       = cmd_t'(in_tuser);
  assign f_tick    = in_tdata[7:0];
  assign f_present = in_tdata[8];
  assign f_time    = in_tdata[40:9];
  assign f_type    = in_tdata[43:41];
  assign f_enable  = in_tdata[44];
  assign f_d       = f_time - rise_r;
  assign kidx      = k_r[SW-1:0];
  assign cd_base   = CAW'(kidx) * CAW'(CD_PER_SLOT);
  assign out_free  = !out_v_r || out_tready;
  assign push_go   = (cnt_r >= CNT_W'(MAX_RES)) || !pend_v_r || out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.res;
  assign out_tdata  = {2'b00, out_r.angle, out_r.ejector, out_r.sensor, out_r.btype};
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= 12'd80;
      zone1_r <= 12'd100;
      zone2_r <= 12'd200;
      zone3_r <= 12'd300;
      kofs_r  <= 12'd20;
      types_r <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_LEN:  if (cfg_wdata != 12'd0) len_r   <= cfg_wdata;
        REG_ZONE1:    if (cfg_wdata != 12'd0) zone1_r <= cfg_wdata;
        REG_ZONE2:    if (cfg_wdata != 12'd0) zone2_r <= cfg_wdata;
        REG_ZONE3:    if (cfg_wdata != 12'd0) zone3_r <= cfg_wdata;
        REG_KICK_OFS: if (cfg_wdata != 12'd0) kofs_r  <= cfg_wdata;
        REG_TYPES:    types_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
    ej_match = NO_EJECTOR;
    for (int e = 2; e >= 0; e--) begin
      if (mtype_r != TYPE_UNKNOWN && types_r[3*e +: 3] == mtype_r) begin
        ej_match = 2'(e);
      end
    end
  end

  always_comb begin
    case (m_r)
      2'd0: span = {1'b0, zone1_r};
      2'd1: span = {1'b0, zone2_r};
      2'd2: span = {1'b0, zone3_r};
      default: begin
        case (ej_r)
          2'd0: span = {1'b0, zone1_r} + {1'b0, kofs_r};
          2'd1: span = {1'b0, zone2_r} + {1'b0, kofs_r};
          default: span = {1'b0, zone3_r} + {1'b0, kofs_r};
        endcase
      end
    endcase
    diff = $signed({1'b0, span}) - $signed({2'b00, len_r});
    mag  = diff[13] ? 13'(-diff) : diff[12:0];
    shifted = {rem_r, num_r[NUM_W-1]};
    if (!neg_r) begin
      qsat = (|q_r[NUM_W-1:31]) ? 32'h7fffffff : {1'b0, q_r[30:0]};
    end else begin
      qsat = ((|q_r[NUM_W-1:32]) || (q_r[31] && (|q_r[30:0]))) ? 32'h80000000
           : (32'd0 - q_r[31:0]);
    end
    cd_diff = $signed({cd_rdata[31], cd_rdata}) - $signed({25'd0, tick_r});
    cd_nv   = (cd_diff[32] != cd_diff[31]) ? 32'h80000000 : cd_diff[31:0];
    end_sum = $signed({s3_r[31], s3_r}) + 33'(END_EXTRA_MS);
    end_v   = (end_sum[32] != end_sum[31]) ? 32'h7fffffff : end_sum[31:0];
    sw_sum  = {1'b0, info_r.sw} + {9'd0, tick_r};
    sw_sat  = sw_sum[16] ? 16'hffff : sw_sum[15:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_FIN;
          if (cmd == CMD_TICK && enabled_r) begin
            state_nxt = S_RDI;
          end else if (cmd == CMD_EDGE && enabled_r && !f_present && rise_v_r &&
                       mtype_r != TYPE_NONE && f_d != 32'd0 && free_any) begin
            state_nxt = S_FMUL;
          end
        end
      end
      S_RDI: begin
        if (k_r == KW'(SLOTS)) begin
          state_nxt = S_FIN;
        end else if (active_r[kidx]) begin
          state_nxt = S_RDC;
        end
      end
      S_RDC: state_nxt = S_CALC;
      S_CALC: begin
        if (j_r < 3'd3 && (cd_nv[31] || cd_nv == 32'd0) && !info_r.flags[j_r[1:0]]) begin
          state_nxt = S_PUSH;
        end else if (j_r == CD_END) begin
          state_nxt = S_SERVO;
        end else begin
          state_nxt = S_RDC;
        end
      end
      S_SERVO: begin
        state_nxt = S_RDI;
        case (info_r.phase)
          PH_TRAVEL:  if (info_r.ej != NO_EJECTOR && le_r[CD_KICK]) state_nxt = S_PUSH;
          PH_KICK:    if (sw_sat >= KICK_MS) state_nxt = S_PUSH;
          PH_RETRACT: if (sw_sat >= RETRACT_MS) state_nxt = S_PUSH;
          default: ;
        endcase
      end
      S_FMUL: state_nxt = S_FDIV;
      S_FDIV: if (bit_r == 6'(NUM_W - 1)) state_nxt = S_FWR;
      S_FWR: begin
        if (m_r == 2'd3) begin
          state_nxt = S_FEND;
        end else if (m_r == 2'd2 && ej_r == NO_EJECTOR) begin
          state_nxt = S_FNK;
        end else begin
          state_nxt = S_FMUL;
        end
      end
      S_FNK:   state_nxt = S_FEND;
      S_FEND:  state_nxt = S_FINFO;
      S_FINFO: state_nxt = S_PUSH;
      S_PUSH:  if (push_go) state_nxt = ret_r;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ret_nxt = ret_r;       enabled_nxt = enabled_r; rise_v_nxt = rise_v_r;
    mtype_nxt = mtype_r;   rise_nxt = rise_r;       d_nxt = d_r;
    active_nxt = active_r; k_nxt = k_r;             j_nxt = j_r;
    tick_nxt = tick_r;     le_nxt = le_r;           info_nxt = info_r;
    evn_nxt = evn_r;       pend_nxt = pend_r;       pend_v_nxt = pend_v_r;
    out_nxt = out_r;       out_last_nxt = out_last_r;
    out_v_nxt = out_v_r && !out_tready;
    cnt_nxt = cnt_r;       ej_nxt = ej_r;           m_nxt = m_r;
    neg_nxt = neg_r;       den_nxt = den_r;         rem_nxt = rem_r;
    num_nxt = num_r;       q_nxt = q_r;             bit_nxt = bit_r;
    s3_nxt = s3_r;
    cd_we = 1'b0;  cd_waddr = cd_base;  cd_wdata = qsat;
    cd_re = 1'b0;  cd_raddr = cd_base + CAW'(j_r);
    inf_we = 1'b0; inf_wdata = info_r;  inf_re = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (cmd)
            CMD_TICK: begin
              tick_nxt = f_tick;
              k_nxt    = '0;
            end
            CMD_EDGE: begin
              if (enabled_r) begin
                if (f_present) begin
                  rise_nxt   = f_time;
                  rise_v_nxt = 1'b1;
                end else if (rise_v_r && mtype_r != TYPE_NONE && f_d != 32'd0) begin
                  d_nxt   = f_d;
                  ej_nxt  = ej_match;
                  m_nxt   = 2'd0;
                  k_nxt   = KW'(free_idx);
                  den_nxt = DEN_W'(len_r) * DEN_W'(MS_PER_S_DIV);
                  if (!free_any) mtype_nxt = TYPE_NONE;
                end
              end
            end
            CMD_SET_TYPE: mtype_nxt = f_type;
            CMD_ENABLE: begin
              enabled_nxt = f_enable;
              if (!f_enable) active_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_RDI: begin
        if (k_r != KW'(SLOTS)) begin
          if (active_r[kidx]) begin
            inf_re = 1'b1;
            j_nxt  = CD_S1;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end
      S_RDC: begin
        if (j_r == CD_S1) info_nxt = inf_rdata;
        cd_re = 1'b1;
      end
      S_CALC: begin
        cd_we    = 1'b1;
        cd_waddr = cd_base + CAW'(j_r);
        cd_wdata = cd_nv;
        le_nxt[j_r] = cd_nv[31] || cd_nv == 32'd0;
        j_nxt = j_r + 3'd1;
        ret_nxt = (j_r == CD_END) ? S_SERVO : S_RDC;
        if (j_r < 3'd3 && (cd_nv[31] || cd_nv == 32'd0) && !info_r.flags[j_r[1:0]]) begin
          info_nxt.flags[j_r[1:0]] = 1'b1;
          evn_nxt = '{res: EV_SENSOR, btype: 3'd0, sensor: 2'(j_r + 3'd1),
                      ejector: 2'd0, angle: 7'd0};
        end
      end
      S_SERVO: begin
        inf_we  = 1'b1;
        k_nxt   = k_r + KW'(1);
        ret_nxt = S_RDI;
        evn_nxt = '{res: EV_SERVO, btype: 3'd0, sensor: 2'd0, ejector: info_r.ej,
                    angle: REST_ANGLE};
        case (info_r.phase)
          PH_TRAVEL: begin
            if (info_r.ej != NO_EJECTOR && le_r[CD_KICK]) begin
              inf_wdata.sw    = 16'd0;
              inf_wdata.phase = PH_KICK;
              evn_nxt.angle   = STRIKE_ANGLE;
            end else if (le_r[CD_END]) begin
              active_nxt[kidx] = 1'b0;
            end
          end
          PH_KICK: begin
            inf_wdata.sw = sw_sat;
            if (sw_sat >= KICK_MS) begin
              inf_wdata.sw    = 16'd0;
              inf_wdata.phase = PH_RETRACT;
            end
          end
          PH_RETRACT: begin
            inf_wdata.sw = sw_sat;
            if (sw_sat >= RETRACT_MS) begin
              active_nxt[kidx] = 1'b0;
              evn_nxt = '{res: EV_EJECT, btype: info_r.btype, sensor: 2'd0,
                          ejector: 2'd0, angle: 7'd0};
            end
          end
          default: ;
        endcase
      end
      S_FMUL: begin
        num_nxt = NUM_W'(d_r) * NUM_W'(mag);
        neg_nxt = diff[13];
        rem_nxt = '0;
        q_nxt   = '0;
        bit_nxt = 6'd0;
      end
      S_FDIV: begin
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        bit_nxt = bit_r + 6'd1;
        if (shifted >= {1'b0, den_r}) begin
          rem_nxt = DEN_W'(shifted - {1'b0, den_r});
          q_nxt   = {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[DEN_W-1:0];
          q_nxt   = {q_r[NUM_W-2:0], 1'b0};
        end
      end
      S_FWR: begin
        cd_we    = 1'b1;
        cd_waddr = cd_base + CAW'(m_r);
        if (m_r == 2'd2) s3_nxt = qsat;
        m_nxt = m_r + 2'd1;
      end
      S_FNK: begin
        cd_we    = 1'b1;
        cd_waddr = cd_base + CAW'(CD_KICK);
        cd_wdata = NO_KICK;
      end
      S_FEND: begin
        cd_we    = 1'b1;
        cd_waddr = cd_base + CAW'(CD_END);
        cd_wdata = end_v;
      end
      S_FINFO: begin
        inf_we    = 1'b1;
        inf_wdata = '{btype: mtype_r, ej: ej_r, flags: 3'd0, phase: PH_TRAVEL, sw: 16'd0};
        active_nxt[kidx] = 1'b1;
        mtype_nxt = TYPE_NONE;
        ret_nxt   = S_FIN;
        evn_nxt   = '{res: EV_NEW_BOX, btype: mtype_r, sensor: 2'd0, ejector: 2'd0,
                      angle: 7'd0};
      end
      S_PUSH: begin
        if (cnt_r < CNT_W'(MAX_RES) && push_go) begin
          if (pend_v_r) begin
            out_nxt      = pend_r;
            out_last_nxt = 1'b0;
            out_v_nxt    = 1'b1;
          end
          pend_nxt   = evn_r;
          pend_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_nxt      = pend_v_r ? pend_r : '{res: EV_NONE, btype: 3'd0, sensor: 2'd0,
                                               ejector: 2'd0, angle: 7'd0};
          out_last_nxt = 1'b1;
          out_v_nxt    = 1'b1;
          pend_v_nxt   = 1'b0;
          cnt_nxt      = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      enabled_r <= 1'b0;
      rise_v_r  <= 1'b0;
      mtype_r   <= TYPE_NONE;
      rise_r    <= 32'd0;
      active_r  <= '0;
      k_r       <= '0;
      j_r       <= '0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      enabled_r <= enabled_nxt;
      rise_v_r  <= rise_v_nxt;
      mtype_r   <= mtype_nxt;
      rise_r    <= rise_nxt;
      active_r  <= active_nxt;
      k_r       <= k_nxt;
      j_r       <= j_nxt;
      pend_v_r  <= pend_v_nxt;
      out_v_r   <= out_v_nxt;
      cnt_r     <= cnt_nxt;
    end
    d_r <= d_nxt;       tick_r <= tick_nxt;   le_r <= le_nxt;     info_r <= info_nxt;
    evn_r <= evn_nxt;   pend_r <= pend_nxt;   out_r <= out_nxt;   out_last_r <= out_last_nxt;
    ej_r <= ej_nxt;     m_r <= m_nxt;         neg_r <= neg_nxt;   den_r <= den_nxt;
    rem_r <= rem_nxt;   num_r <= num_nxt;     q_r <= q_nxt;       bit_r <= bit_nxt;
    s3_r <= s3_nxt;
  end

  cbes_ram #(.WIDTH(32), .DEPTH(CD_DEPTH), .AW(CAW)) u_cd_ram (
    .clk   (clk),
    .we    (cd_we),
    .waddr (cd_waddr),
    .wdata (cd_wdata),
    .re    (cd_re),
    .raddr (cd_raddr),
    .rdata (cd_rdata)
  );

  cbes_ram #(.WIDTH(IW), .DEPTH(SLOTS), .AW(SW)) u_info_ram (
    .clk   (clk),
    .we    (inf_we),
    .waddr (kidx),
    .wdata (inf_wdata),
    .re    (inf_re),
    .raddr (kidx),
    .rdata (inf_rdata)
  );

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r && cnt_r == '0)
    else $error("pending event or count left over in idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("event count beyond limit");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (state_r == S_IDLE && out_v_r && out_last_r))
    else $error("final item not marked last");

  a_push_ret: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PUSH |-> (ret_r == S_RDC || ret_r == S_SERVO || ret_r == S_RDI ||
                           ret_r == S_FIN))
    else $error("bad return state from push");

endmodule

// ===== rtl/core/cbes_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cbes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the conveyor blind ejector scheduler: item driver, event monitor.
`timescale 1ns / 1ps
module tb;
  import cbes_pkg::*;

  localparam int NSLOT = 8;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    cmd_t        cmd;
    bit [7:0]    tick_ms;
    bit          present;
    bit [31:0]   stamp;
    bit [2:0]    btype;
    bit          en;
  } belt_item_t;

  typedef struct {
    event_t    res;
    bit [2:0]  btype;
    bit [1:0]  sensor;
    bit [1:0]  ejector;
    bit [6:0]  angle;
    bit        last;
  } belt_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;   // cmd
  logic [47:0] in_tdata = '0;   // tick_ms, object_present, time_us, box_type, enable
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [2:0]  out_tuser;       // event_res
  logic [15:0] out_tdata;       // event_box_type, sensor_index, ejector_index, servo_angle
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_wdata = '0;

  conveyor_blind_ejector_scheduler u_top (.*);

  always #10 clk = ~clk;

  belt_item_t  pending_items[$];
  belt_event_t events_due[$];
  belt_event_t burst[$];
  belt_item_t  cur_item;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          errors = 0;
  int          stall_cnt = 0;
  int          hold_cnt = 0;
  bit          hold_req = 0;
  int          dmax = 150000;

  // scheduler state
  int        len_mm = 80, zone_mm[3] = '{100, 200, 300}, kick_mm = 20;
  bit [8:0]  ej_types = '0;
  bit        on_st = 0, rise_ok = 0;
  bit [2:0]  meas_type = '0;
  bit [31:0] rise_stamp = '0;
  bit        s_act[NSLOT];
  bit [2:0]  s_type[NSLOT];
  bit [1:0]  s_ej[NSLOT];
  int        s_cd[NSLOT][5];
  bit [2:0]  s_pass[NSLOT];
  bit [1:0]  s_ph[NSLOT];
  bit [15:0] s_sw[NSLOT];

  function automatic int sat32(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(32'sh80000000) + 0 && v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic int travel_ms(bit [31:0] d, longint span);
    longint l = len_mm;
    return sat32((longint'({32'b0, d}) * (span - l)) / (1000 * l));
  endfunction

  function automatic void note(event_t ev, bit [2:0] ty, bit [1:0] si, bit [1:0] ei,
                               bit [6:0] ang);
    belt_event_t e;
    if (burst.size() >= MAX_RES) return;
    e.res = ev; e.btype = ty; e.sensor = si; e.ejector = ei; e.angle = ang; e.last = 0;
    burst.push_back(e);
  endfunction

  function automatic void place_box(bit [31:0] now);
    bit [31:0] d;
    bit [1:0]  ej = NO_EJECTOR;
    if (!rise_ok || meas_type == TYPE_NONE) return;
    d = now - rise_stamp;
    if (d == 0) return;
    if (meas_type != TYPE_UNKNOWN)
      for (int e = 2; e >= 0; e--)
        if (ej_types[3*e +: 3] == meas_type) ej = 2'(e);
    for (int k = 0; k < NSLOT; k++) begin
      if (s_act[k]) continue;
      s_act[k] = 1; s_type[k] = meas_type; s_ej[k] = ej;
      for (int j = 0; j < 3; j++) s_cd[k][j] = travel_ms(d, zone_mm[j]);
      s_cd[k][CD_END] = sat32(longint'(s_cd[k][CD_S3]) + END_EXTRA_MS);
      s_cd[k][CD_KICK] = (ej != NO_EJECTOR) ? travel_ms(d, zone_mm[ej] + kick_mm)
                                            : int'(NO_KICK);
      s_pass[k] = 0; s_ph[k] = PH_TRAVEL; s_sw[k] = 0;
      note(EV_NEW_BOX, meas_type, 0, 0, 0);
      break;
    end
    meas_type = TYPE_NONE;
  endfunction

  function automatic bit [15:0] sw_add(bit [15:0] s, bit [7:0] t);
    int v = s + t;
    return (v > 16'hffff) ? 16'hffff : v[15:0];
  endfunction

  function automatic void advance_belt(bit [7:0] t);
    for (int k = 0; k < NSLOT; k++) begin
      if (!s_act[k]) continue;
      for (int j = 0; j < 5; j++) s_cd[k][j] = sat32(longint'(s_cd[k][j]) - t);
      for (int j = 0; j < 3; j++)
        if (s_cd[k][j] <= 0 && !s_pass[k][j]) begin
          note(EV_SENSOR, 0, j + 1, 0, 0);
          s_pass[k][j] = 1;
        end
      case (s_ph[k])
        PH_TRAVEL: begin
          if (s_ej[k] != NO_EJECTOR && s_cd[k][CD_KICK] <= 0) begin
            note(EV_SERVO, 0, 0, s_ej[k], STRIKE_ANGLE);
            s_sw[k] = 0; s_ph[k] = PH_KICK;
          end else if (s_cd[k][CD_END] <= 0) s_act[k] = 0;
        end
        PH_KICK: begin
          s_sw[k] = sw_add(s_sw[k], t);
          if (s_sw[k] >= KICK_MS) begin
            note(EV_SERVO, 0, 0, s_ej[k], REST_ANGLE);
            s_sw[k] = 0; s_ph[k] = PH_RETRACT;
          end
        end
        PH_RETRACT: begin
          s_sw[k] = sw_add(s_sw[k], t);
          if (s_sw[k] >= RETRACT_MS) begin
            note(EV_EJECT, s_type[k], 0, 0, 0);
            s_act[k] = 0;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void schedule_item(belt_item_t it);
    burst.delete();
    case (it.cmd)
      CMD_TICK: if (on_st) advance_belt(it.tick_ms);
      CMD_EDGE: if (on_st) begin
        if (it.present) begin
          rise_stamp = it.stamp; rise_ok = 1;
        end else place_box(it.stamp);
      end
      CMD_SET_TYPE: meas_type = it.btype;
      default: begin
        on_st = it.en;
        if (!on_st) foreach (s_act[k]) s_act[k] = 0;
      end
    endcase
    if (burst.size() == 0) note(EV_NONE, 0, 0, 0, 0);
    burst[burst.size() - 1].last = 1;
    foreach (burst[i]) events_due.push_back(burst[i]);
  endfunction

  function automatic void queue_item(cmd_t c, bit [31:0] v);
    belt_item_t it;
    it.cmd = c; it.tick_ms = $urandom; it.present = $urandom; it.stamp = $urandom;
    it.btype = $urandom; it.en = $urandom;
    case (c)
      CMD_TICK:     it.tick_ms = v[7:0];
      CMD_SET_TYPE: it.btype = v[2:0];
      CMD_ENABLE:   it.en = v[0];
      default: ;
    endcase
    pending_items.push_back(it);
  endfunction

  function automatic void queue_edge(bit p, bit [31:0] t);
    queue_item(CMD_EDGE, 0);
    pending_items[pending_items.size() - 1].present = p;
    pending_items[pending_items.size() - 1].stamp = t;
  endfunction

  task automatic write_reg(bit [2:0] idx, bit [11:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    case (idx)
      REG_BOX_LEN:  if (val != 0) len_mm = val;
      REG_ZONE1:    if (val != 0) zone_mm[0] = val;
      REG_ZONE2:    if (val != 0) zone_mm[1] = val;
      REG_ZONE3:    if (val != 0) zone_mm[2] = val;
      REG_KICK_OFS: if (val != 0) kick_mm = val;
      default:      ej_types = val[8:0];
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_tvalid || events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic fill_random(int n);
    int cnt = 0;
    int r;
    bit [31:0] t, d;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        queue_item(CMD_SET_TYPE, ($urandom_range(9) < 7) ? $urandom_range(7, 2)
                                                         : $urandom_range(1));
        t = $urandom;
        r = $urandom_range(99);
        d = (r < 4) ? 0 : (r < 7) ? $urandom : $urandom_range(dmax, 1);
        queue_edge(1, t);
        queue_edge(0, t + d);
        cnt += 3;
        repeat ($urandom_range(3, 1)) begin
          queue_item(CMD_TICK, $urandom_range(255));
          cnt++;
        end
      end else if (r < 85) begin
        queue_item(CMD_TICK, $urandom_range(255));
        cnt++;
      end else if (r < 91) begin
        queue_edge($urandom, $urandom);
        cnt++;
      end else if (r < 96) begin
        queue_item(CMD_SET_TYPE, $urandom_range(7));
        cnt++;
      end else begin
        queue_item(CMD_ENABLE, 0);
        queue_item(CMD_ENABLE, 1);
        cnt += 2;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) schedule_item(cur_item);
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_tuser <= cur_item.cmd;
          in_tdata <= {3'b0, cur_item.en, cur_item.btype, cur_item.stamp,
                       cur_item.present, cur_item.tick_ms};
          in_tvalid <= 1'b1;
        end else in_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    belt_event_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (events_due.size() == 0) begin
          errors++;
          $display("%0t unexpected event: exp none act res=%0d data=%h last=%b",
                   $time, out_tuser, out_tdata, out_tlast);
        end else begin
          e = events_due.pop_front();
          if (out_tuser !== e.res || out_tdata !== {2'b0, e.angle, e.ejector, e.sensor,
              e.btype} || out_tlast !== e.last) begin
            errors++;
            $display("%0t mismatch: exp res=%0d ty=%0d si=%0d ei=%0d ang=%0d last=%b",
                     $time, e.res, e.btype, e.sensor, e.ejector, e.angle, e.last);
            $display("%0t           act res=%0d ty=%0d si=%0d ei=%0d ang=%0d last=%b",
                     $time, out_tuser, out_tdata[2:0], out_tdata[4:3], out_tdata[6:5],
                     out_tdata[13:7], out_tlast);
          end
        end
      end
      if (hold_req && hold_cnt == 0) begin
        hold_cnt <= HOLD_CYCLES;
        hold_req <= 0;
        out_tready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    foreach (s_act[k]) s_act[k] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_TYPES, {3'd4, 3'd3, 3'd2});
    end_writes();
    send_idle_pct = 19; recv_idle_pct = 51;
    queue_item(CMD_TICK, 5);
    queue_edge(0, 32'd1000);
    queue_item(CMD_ENABLE, 1);
    queue_edge(0, 32'd500);
    queue_item(CMD_SET_TYPE, 2);
    queue_edge(1, 32'd0);
    queue_edge(0, 32'd0);
    queue_edge(1, 32'd100);
    queue_edge(0, 32'd80100);
    queue_item(CMD_SET_TYPE, 1);
    queue_edge(1, 32'd200000);
    queue_edge(0, 32'd260000);
    queue_item(CMD_SET_TYPE, 0);
    queue_edge(0, 32'd300000);
    queue_item(CMD_SET_TYPE, 7);
    queue_edge(0, 32'd350000);
    queue_edge(1, 32'hffffffff);
    queue_item(CMD_SET_TYPE, 3);
    queue_edge(0, 32'h00013880);
    queue_item(CMD_TICK, 255);
    queue_item(CMD_TICK, 0);
    queue_item(CMD_ENABLE, 1);
    repeat (3) queue_item(CMD_TICK, 255);
    queue_item(CMD_ENABLE, 0);
    queue_item(CMD_TICK, 255);
    queue_item(CMD_ENABLE, 1);
    fill_random(60);
    drain();

    write_reg(REG_BOX_LEN, 12'd4095);
    write_reg(REG_ZONE1, 12'd1);
    write_reg(REG_ZONE2, 12'd50);
    write_reg(REG_ZONE3, 12'd4095);
    write_reg(REG_KICK_OFS, 12'd4095);
    write_reg(REG_TYPES, 12'hfff);
    write_reg(REG_ZONE1, 12'd0);
    end_writes();
    send_idle_pct = 51; recv_idle_pct = 19;
    fill_random(40);
    drain();

    write_reg(REG_TYPES, {3'd5, 3'd6, 3'd7});
    write_reg(REG_KICK_OFS, 12'd0);
    end_writes();
    fill_random(35);
    drain();

    write_reg(REG_BOX_LEN, 12'd1);
    write_reg(REG_ZONE1, 12'd4095);
    write_reg(REG_ZONE2, 12'd2000);
    write_reg(REG_ZONE3, 12'd3000);
    write_reg(REG_KICK_OFS, 12'd1);
    write_reg(REG_TYPES, {3'd2, 3'd3, 3'd2});
    write_reg(REG_BOX_LEN, 12'd0);
    end_writes();
    send_idle_pct = 0; recv_idle_pct = 0;
    dmax = 300;
    hold_req = 1;
    fill_random(70);
    drain();

    if (errors == 0 && events_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
